// ===== rtl/segregated_fit_heap_allocator_assert.svh =====
// assertion macros for the heap allocator, sampled on clk, off during reset
`ifndef SEGREGATED_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// expr must never hold
`define SFHA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// when ante holds, cons holds in the next cycle
`define SFHA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sfha_pkg.sv =====
// ----------------------------------------------------------------------------
// sfha_pkg
// shared constants, status codes and the heap memory request type
// ----------------------------------------------------------------------------
package sfha_pkg;

  localparam int unsigned DEF_HEAP_BYTES  = 65536;
  localparam int unsigned DEF_NUM_CLASSES = 8;
  localparam int unsigned DEF_CHUNK_BYTES = 4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO_SIZE = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;

  typedef struct packed {
    logic        we;
    logic [31:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/segregated_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// segregated_fit_heap_allocator
// boundary-tagged heap with segregated free lists, allocate and free
// ----------------------------------------------------------------------------
// usage:
//   in_* beat carries op, req_size and block_addr; out_* beat returns
//   result_addr and status, one result beat per request beat.
//   block tags and list links sit in one single-port word memory; a step
//   does at most one read or one write, read data arrives the next cycle.
//   a zero-size request goes straight to its result; a free clears the
//   tags, merges with free neighbours and pushes the block on its list,
//   or is rejected; an allocate searches the lists from its size class
//   up, then places the block with or without a split, extending the
//   break first when no fit is found. one request is in flight at a time,
//   the next can be taken in the same cycle as the result appears.
//   reset: the memory is rewritten word by word with the initial layout,
//   HEAP_BYTES/4 words (16384 by default), with in_ready low meanwhile.
//   stall: a finished result waits in the output register; a new request
//   is taken meanwhile and only its completion waits for out_ready.
//   HEAP_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module segregated_fit_heap_allocator
  import sfha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES  = DEF_HEAP_BYTES,
  parameter int unsigned NUM_CLASSES = DEF_NUM_CLASSES,
  parameter int unsigned CHUNK_BYTES = DEF_CHUNK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_addr,
  output logic [1:0]  out_status
);

  `include "segregated_fit_heap_allocator_assert.svh"

  localparam int unsigned HW   = HEAP_BYTES / 4;
  localparam int unsigned AW   = $clog2(HW);
  localparam int unsigned CW   = $clog2(NUM_CLASSES);
  localparam int unsigned BW   = $clog2(HEAP_BYTES + 1);
  localparam int unsigned WALK = HEAP_BYTES / 16;
  localparam int unsigned SW   = $clog2(WALK + 1);

  localparam logic [31:0] HEAP32    = 32'(HEAP_BYTES);
  localparam logic [31:0] CHUNK32   = 32'(CHUNK_BYTES);
  localparam logic [31:0] LIST_BASE = 32'(NUM_CLASSES * 4 + 4);
  localparam logic [31:0] PRO_HDR   = LIST_BASE + 32'(16 * NUM_CLASSES);
  localparam logic [31:0] FIRST_BP  = PRO_HDR + 32'd12;
  localparam int unsigned CHUNK_W   = CHUNK_BYTES / 4;
  localparam logic [31:0] GSZ0      = 32'((CHUNK_W + (CHUNK_W % 2)) * 4);
  localparam logic        FITS      = (GSZ0 <= HEAP32 - FIRST_BP);
  localparam logic [31:0] BRK0      = FITS ? FIRST_BP + GSZ0 : FIRST_BP;

  function automatic logic [CW-1:0] class_of(input logic [31:0] sz);
    logic [31:0] n;
    int          bl;
    n  = sz >> 6;
    bl = 0;
    for (int i = 0; i < 32; i++) begin
      if (n[i]) bl = i + 1;
    end
    if (bl > int'(NUM_CLASSES) - 1) bl = int'(NUM_CLASSES) - 1;
    return bl[CW-1:0];
  endfunction

  localparam logic [CW-1:0] C0 = class_of(GSZ0);
  localparam logic [31:0] SENT_C0 = LIST_BASE + 32'(16) * 32'(C0) + 32'd4;

  function automatic logic [31:0] init_word(input logic [AW-1:0] idx);
    logic [31:0] a;
    logic [31:0] v;
    logic [31:0] sb;
    a = 32'(idx) << 2;
    v = '0;
    for (int i = 0; i < int'(NUM_CLASSES); i++) begin
      sb = LIST_BASE + 32'(16 * i) + 32'd4;
      if (a == 32'(i * 4)) v = sb;
      if (a == sb || a == sb + 32'd4) begin
        v = (FITS && i == int'(C0)) ? FIRST_BP : sb;
      end
    end
    if (a == PRO_HDR || a == PRO_HDR + 32'd4) v = 32'd8 | ALLOC_BIT;
    if (a == PRO_HDR + 32'd8) v = FITS ? GSZ0 : ALLOC_BIT;
    if (FITS) begin
      if (a == FIRST_BP || a == FIRST_BP + 32'd4) v = SENT_C0;
      if (a == FIRST_BP + GSZ0 - 32'd8) v = GSZ0;
      if (a == FIRST_BP + GSZ0 - 32'd4) v = ALLOC_BIT;
    end
    return v;
  endfunction

  typedef enum logic [5:0] {
    ST_INIT, ST_IDLE, ST_FF_HEAD, ST_FF_FIRST, ST_FF_BP, ST_FF_CHK,
    ST_GROW, ST_G_W1, ST_G_W2, ST_G_W3,
    ST_M_R0, ST_M_R1, ST_M_R2, ST_M_R3,
    ST_MA_R, ST_MA_W1, ST_MA_W2, ST_MB_R, ST_MB_W1, ST_MB_W2,
    ST_MC_U2, ST_MC_R0, ST_MC_R1, ST_MC_R2, ST_MC_W1, ST_MC_W2,
    ST_P_R0, ST_P_R1, ST_P_W0, ST_P_W1, ST_P_W2, ST_P_W3,
    ST_U_R0, ST_U_R1, ST_U_R2, ST_U_W,
    ST_PL_0, ST_PL_R, ST_PL_D, ST_PL_S1, ST_PL_S2, ST_PL_S3, ST_PL_N1,
    ST_F_R, ST_F_C, ST_F_W2, ST_DONE
  } state_t;

  state_t state_r, state_nxt, uret_r, uret_nxt, mret_r, mret_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [BW-1:0] brk_r, brk_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] cls_r, cls_nxt;
  logic [31:0] bp_r, bp_nxt, size_r, size_nxt, nb_r, nb_nxt, pb_r, pb_nxt;
  logic [31:0] p_r, p_nxt, n_r, n_nxt, t_r, t_nxt, nfoot_r, nfoot_nxt;
  logic [31:0] head_r, head_nxt, first_r, first_nxt, ux_r, ux_nxt;
  logic [31:0] asize_r, asize_nxt;
  logic        pa_r, pa_nxt;
  logic [15:0] res_r, res_nxt, oaddr_r, oaddr_nxt;
  logic [1:0]  stat_r, stat_nxt, ostat_r, ostat_nxt;
  logic        ovalid_r, ovalid_nxt;

  mem_req_t    mreq;
  logic [31:0] rd_q;
  logic [31:0] rd_tag;
  logic [31:0] brk32;
  logic [31:0] ext;
  logic [31:0] gsz;
  logic [31:0] addr32;
  logic [31:0] req_asize;

  sfha_ram #(.HEAP_BYTES(HEAP_BYTES)) u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rd_q)
  );

  assign rd_tag    = rd_q & SIZE_MASK;
  assign brk32     = 32'(brk_r);
  assign ext       = (asize_r > CHUNK32) ? asize_r : CHUNK32;
  assign gsz       = ((ext >> 2) + ((ext >> 2) & 32'd1)) << 2;
  assign addr32    = {16'd0, in_block_addr};
  assign req_asize = (in_req_size <= 16'd8) ? 32'd16
                   : ((32'(in_req_size) + 32'd15) & SIZE_MASK);

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = ovalid_r;
  assign out_result_addr = oaddr_r;
  assign out_status      = ostat_r;

  always_comb begin
    state_nxt = state_r;  uret_nxt = uret_r;   mret_nxt = mret_r;
    idx_nxt   = idx_r;    brk_nxt  = brk_r;    steps_nxt = steps_r;
    cls_nxt   = cls_r;    bp_nxt   = bp_r;     size_nxt = size_r;
    nb_nxt    = nb_r;     pb_nxt   = pb_r;     p_nxt    = p_r;
    n_nxt     = n_r;      t_nxt    = t_r;      nfoot_nxt = nfoot_r;
    head_nxt  = head_r;   first_nxt = first_r; ux_nxt   = ux_r;
    asize_nxt = asize_r;  pa_nxt   = pa_r;     res_nxt  = res_r;
    stat_nxt  = stat_r;   oaddr_nxt = oaddr_r; ostat_nxt = ostat_r;
    ovalid_nxt = ovalid_r && !out_ready;
    mreq = '0;

    case (state_r)
      ST_INIT: begin
        mreq.we    = 1'b1;
        mreq.addr  = 32'(idx_r) << 2;
        mreq.wdata = init_word(idx_r);
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == AW'(HW - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt  = '0;
          stat_nxt = STAT_OK;
          if (in_op == OP_ALLOC) begin
            asize_nxt = req_asize;
            cls_nxt   = class_of(req_asize);
            if (in_req_size == 16'd0) begin
              stat_nxt  = STAT_ZERO_SIZE;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_FF_HEAD;
            end
          end else begin
            bp_nxt = addr32;
            if (addr32 < FIRST_BP || addr32 >= brk32 ||
                ((addr32 - FIRST_BP) & 32'd7) != 32'd0) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_F_R;
            end
          end
        end
      end
      ST_FF_HEAD: begin
        mreq.addr = 32'(cls_r) << 2;
        state_nxt = ST_FF_FIRST;
      end
      ST_FF_FIRST: begin
        mreq.addr = rd_q + 32'd4;
        steps_nxt = '0;
        state_nxt = ST_FF_BP;
      end
      ST_FF_BP: begin
        bp_nxt    = rd_q;
        mreq.addr = rd_q - 32'd4;
        state_nxt = ST_FF_CHK;
      end
      ST_FF_CHK: begin
        if (rd_tag != 32'd0 && 32'(steps_r) < 32'(WALK)) begin
          if (asize_r <= rd_tag) begin
            // a fit at offset zero counts as no fit
            state_nxt = (bp_r == 32'd0) ? ST_GROW : ST_PL_0;
          end else begin
            mreq.addr = bp_r + 32'd4;
            steps_nxt = steps_r + 1'b1;
            state_nxt = ST_FF_BP;
          end
        end else if (cls_r == CW'(NUM_CLASSES - 1)) begin
          state_nxt = ST_GROW;
        end else begin
          cls_nxt   = cls_r + 1'b1;
          state_nxt = ST_FF_HEAD;
        end
      end
      ST_GROW: begin
        if (brk32 > HEAP32 || gsz > HEAP32 - brk32) begin
          stat_nxt  = STAT_EXHAUSTED;
          state_nxt = ST_DONE;
        end else begin
          bp_nxt    = brk32;
          size_nxt  = gsz;
          brk_nxt   = BW'(brk32 + gsz);
          state_nxt = ST_G_W1;
        end
      end
      ST_G_W1: begin
        mreq = '{we: 1'b1, addr: bp_r - 32'd4, wdata: size_r};
        state_nxt = ST_G_W2;
      end
      ST_G_W2: begin
        mreq = '{we: 1'b1, addr: bp_r + size_r - 32'd8, wdata: size_r};
        state_nxt = ST_G_W3;
      end
      ST_G_W3: begin
        mreq = '{we: 1'b1, addr: bp_r + size_r - 32'd4, wdata: ALLOC_BIT};
        mret_nxt  = ST_PL_0;
        state_nxt = ST_M_R0;
      end
      ST_M_R0: begin
        mreq.addr = bp_r - 32'd4;
        state_nxt = ST_M_R1;
      end
      ST_M_R1: begin
        size_nxt  = rd_tag;
        mreq.addr = bp_r - 32'd8;
        state_nxt = ST_M_R2;
      end
      ST_M_R2: begin
        pa_nxt    = rd_q[0];
        t_nxt     = rd_tag;
        nb_nxt    = bp_r + size_r;
        mreq.addr = bp_r + size_r - 32'd4;
        state_nxt = ST_M_R3;
      end
      ST_M_R3: begin
        pb_nxt = bp_r - t_r;
        if (pa_r && !rd_q[0]) begin
          ux_nxt = nb_r;  uret_nxt = ST_MA_R;  state_nxt = ST_U_R0;
        end else if (!pa_r && rd_q[0]) begin
          ux_nxt = bp_r - t_r;  uret_nxt = ST_MB_R;  state_nxt = ST_U_R0;
        end else if (!pa_r && !rd_q[0]) begin
          ux_nxt = nb_r;  uret_nxt = ST_MC_U2;  state_nxt = ST_U_R0;
        end else begin
          state_nxt = ST_P_R0;
        end
      end
      ST_MA_R: begin
        mreq.addr = nb_r - 32'd4;
        state_nxt = ST_MA_W1;
      end
      ST_MA_W1: begin
        size_nxt  = size_r + rd_tag;
        mreq = '{we: 1'b1, addr: bp_r - 32'd4, wdata: size_r + rd_tag};
        state_nxt = ST_MA_W2;
      end
      ST_MA_W2: begin
        mreq = '{we: 1'b1, addr: bp_r + size_r - 32'd8, wdata: size_r};
        state_nxt = ST_P_R0;
      end
      ST_MB_R: begin
        mreq.addr = pb_r - 32'd4;
        state_nxt = ST_MB_W1;
      end
      ST_MB_W1: begin
        size_nxt  = size_r + rd_tag;
        mreq = '{we: 1'b1, addr: bp_r + size_r - 32'd8, wdata: size_r + rd_tag};
        state_nxt = ST_MB_W2;
      end
      ST_MB_W2: begin
        mreq = '{we: 1'b1, addr: pb_r - 32'd4, wdata: size_r};
        bp_nxt    = pb_r;
        state_nxt = ST_P_R0;
      end
      ST_MC_U2: begin
        ux_nxt    = pb_r;
        uret_nxt  = ST_MC_R0;
        state_nxt = ST_U_R0;
      end
      ST_MC_R0: begin
        mreq.addr = nb_r - 32'd4;
        state_nxt = ST_MC_R1;
      end
      ST_MC_R1: begin
        nfoot_nxt = nb_r + rd_tag - 32'd8;
        mreq.addr = pb_r - 32'd4;
        state_nxt = ST_MC_R2;
      end
      ST_MC_R2: begin
        t_nxt     = rd_tag;
        mreq.addr = nfoot_r;
        state_nxt = ST_MC_W1;
      end
      ST_MC_W1: begin
        size_nxt  = size_r + t_r + rd_tag;
        mreq = '{we: 1'b1, addr: pb_r - 32'd4, wdata: size_r + t_r + rd_tag};
        state_nxt = ST_MC_W2;
      end
      ST_MC_W2: begin
        mreq = '{we: 1'b1, addr: nfoot_r, wdata: size_r};
        bp_nxt    = pb_r;
        state_nxt = ST_P_R0;
      end
      ST_P_R0: begin
        mreq.addr = 32'(class_of(size_r)) << 2;
        state_nxt = ST_P_R1;
      end
      ST_P_R1: begin
        head_nxt  = rd_q;
        mreq.addr = rd_q + 32'd4;
        state_nxt = ST_P_W0;
      end
      ST_P_W0: begin
        first_nxt = rd_q;
        mreq = '{we: 1'b1, addr: bp_r, wdata: head_r};
        state_nxt = ST_P_W1;
      end
      ST_P_W1: begin
        mreq = '{we: 1'b1, addr: bp_r + 32'd4, wdata: first_r};
        state_nxt = ST_P_W2;
      end
      ST_P_W2: begin
        mreq = '{we: 1'b1, addr: first_r, wdata: bp_r};
        state_nxt = ST_P_W3;
      end
      ST_P_W3: begin
        mreq = '{we: 1'b1, addr: head_r + 32'd4, wdata: bp_r};
        state_nxt = mret_r;
      end
      ST_U_R0: begin
        mreq.addr = ux_r;
        state_nxt = ST_U_R1;
      end
      ST_U_R1: begin
        p_nxt     = rd_q;
        mreq.addr = ux_r + 32'd4;
        state_nxt = ST_U_R2;
      end
      ST_U_R2: begin
        n_nxt     = rd_q;
        mreq = '{we: 1'b1, addr: p_r + 32'd4, wdata: rd_q};
        state_nxt = ST_U_W;
      end
      ST_U_W: begin
        mreq = '{we: 1'b1, addr: n_r, wdata: p_r};
        state_nxt = uret_r;
      end
      ST_PL_0: begin
        if (bp_r == 32'd0) begin
          // extension merged down to offset zero
          stat_nxt  = STAT_EXHAUSTED;
          state_nxt = ST_DONE;
        end else begin
          res_nxt   = bp_r[15:0];
          ux_nxt    = bp_r;
          uret_nxt  = ST_PL_R;
          state_nxt = ST_U_R0;
        end
      end
      ST_PL_R: begin
        mreq.addr = bp_r - 32'd4;
        state_nxt = ST_PL_D;
      end
      ST_PL_D: begin
        t_nxt = rd_tag;
        if (rd_tag >= asize_r && rd_tag - asize_r >= 32'd16) begin
          mreq = '{we: 1'b1, addr: bp_r - 32'd4, wdata: asize_r | ALLOC_BIT};
          state_nxt = ST_PL_S1;
        end else begin
          mreq = '{we: 1'b1, addr: bp_r - 32'd4, wdata: rd_tag | ALLOC_BIT};
          state_nxt = ST_PL_N1;
        end
      end
      ST_PL_S1: begin
        mreq = '{we: 1'b1, addr: bp_r + asize_r - 32'd8, wdata: asize_r | ALLOC_BIT};
        state_nxt = ST_PL_S2;
      end
      ST_PL_S2: begin
        mreq = '{we: 1'b1, addr: bp_r + asize_r - 32'd4, wdata: t_r - asize_r};
        state_nxt = ST_PL_S3;
      end
      ST_PL_S3: begin
        mreq = '{we: 1'b1, addr: bp_r + t_r - 32'd8, wdata: t_r - asize_r};
        bp_nxt    = bp_r + asize_r;
        mret_nxt  = ST_DONE;
        state_nxt = ST_M_R0;
      end
      ST_PL_N1: begin
        mreq = '{we: 1'b1, addr: bp_r + t_r - 32'd8, wdata: t_r | ALLOC_BIT};
        state_nxt = ST_DONE;
      end
      ST_F_R: begin
        mreq.addr = bp_r - 32'd4;
        state_nxt = ST_F_C;
      end
      ST_F_C: begin
        if (!rd_q[0] || rd_tag < 32'd16 || rd_tag > brk32 - bp_r) begin
          state_nxt = ST_DONE;
        end else begin
          size_nxt  = rd_tag;
          mreq = '{we: 1'b1, addr: bp_r - 32'd4, wdata: rd_tag};
          state_nxt = ST_F_W2;
        end
      end
      ST_F_W2: begin
        mreq = '{we: 1'b1, addr: bp_r + size_r - 32'd8, wdata: size_r};
        mret_nxt  = ST_DONE;
        state_nxt = ST_M_R0;
      end
      ST_DONE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          oaddr_nxt  = res_r;
          ostat_nxt  = stat_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      uret_r   <= ST_DONE;
      mret_r   <= ST_DONE;
      idx_r    <= '0;
      brk_r    <= BW'(BRK0);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      uret_r   <= uret_nxt;
      mret_r   <= mret_nxt;
      idx_r    <= idx_nxt;
      brk_r    <= brk_nxt;
      ovalid_r <= ovalid_nxt;
    end
    steps_r <= steps_nxt;  cls_r   <= cls_nxt;   bp_r    <= bp_nxt;
    size_r  <= size_nxt;   nb_r    <= nb_nxt;    pb_r    <= pb_nxt;
    p_r     <= p_nxt;      n_r     <= n_nxt;     t_r     <= t_nxt;
    nfoot_r <= nfoot_nxt;  head_r  <= head_nxt;  first_r <= first_nxt;
    ux_r    <= ux_nxt;     asize_r <= asize_nxt; pa_r    <= pa_nxt;
    res_r   <= res_nxt;    stat_r  <= stat_nxt;  oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
  end

  `SFHA_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != ST_IDLE,
    "accepted request did not start work")
  `SFHA_NEVER(a_fail_has_no_addr,
    out_valid && out_status != STAT_OK && out_result_addr != 16'd0,
    "failed allocate returned an address")
  `SFHA_NEXT(a_break_monotonic, state_r != ST_INIT, brk_r >= $past(brk_r),
    "break moved backward")
  `SFHA_NEVER(a_break_in_heap, 32'(brk_r) > HEAP32, "break beyond heap end")

endmodule

// ===== rtl/sfha_ram.sv =====
// ----------------------------------------------------------------------------
// sfha_ram
// single-port heap word memory, byte addressed, registered read data
// ----------------------------------------------------------------------------
module sfha_ram
  import sfha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES = DEF_HEAP_BYTES
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rdata
);

  localparam int unsigned AW = $clog2(HEAP_BYTES / 4);

  logic [31:0] mem [HEAP_BYTES / 4];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW+1:2]] <= req.wdata;
    end
    rdata <= mem[req.addr[AW+1:2]];
  end

endmodule
